// ===== rtl/core/assert_macros.svh =====
// assertion macros for the text console writer checks
// expects signals named clock and reset in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TCW_ASSERT_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("text console writer: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("text console writer: next-cycle check failed");

`endif

// ===== rtl/core/tcw_pkg.sv =====
// shared types and constants for the text console writer
// no dependencies; imported by tcw_ctrl, tcw_datapath and the top level
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam int FUNC_W       = 1;
   localparam int CHAR_W       = 8;
   localparam int READ_INDEX_W = 11;
   localparam int COLOR_W      = 8;
   localparam int CELL_W       = CHAR_W + COLOR_W;
   localparam int ROW_OUT_W    = 5;
   localparam int COL_OUT_W    = 7;

   localparam logic [FUNC_W-1:0]  FUNC_PUT  = 1'b0;
   localparam logic [FUNC_W-1:0]  FUNC_READ = 1'b1;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'h0A;
   localparam logic [CHAR_W-1:0]  SPACE_CODE       = 8'h20;
   localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;
   localparam logic [CELL_W-1:0]  RESET_CELL       = {TEXT_COLOR_RESET, SPACE_CODE};

   typedef struct packed {
      logic [FUNC_W-1:0]       func;
      logic [CHAR_W-1:0]       char_code;
      logic [READ_INDEX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0]    cell_entry;
      logic [ROW_OUT_W-1:0] cursor_row;
      logic [COL_OUT_W-1:0] cursor_col;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_BLANK,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic clear_write;
      logic capture;
      logic exec_item;
      logic blank_write;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic blank_last;
      logic is_read;
      logic need_scroll;
   } dp_status_type;

endpackage

// ===== rtl/core/tcw_ctrl.sv =====
// controller state machine of the text console writer
// depends on tcw_pkg; drives datapath commands and the channel handshakes
`timescale 1ns / 1ps

module tcw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  tcw_pkg::dp_status_type status,
   output tcw_pkg::dp_cmd_type    cmd
);
   import tcw_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.is_read)          state_in = ST_READ;
            else if (status.need_scroll) state_in = ST_BLANK;
            else                         state_in = ST_FINISH;
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_BLANK: begin
            if (status.blank_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR:  cmd.clear_write = 1'b1;
         ST_IDLE:   cmd.capture     = req_valid;
         ST_EXEC:   cmd.exec_item   = 1'b1;
         ST_BLANK:  cmd.blank_write = 1'b1;
         ST_FINISH: cmd.load_rsp    = out_free;
         default:   cmd = '0;
      endcase
   end

   // result register: loaded once per item, held while the receiver stalls
   always_comb begin
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else              rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/tcw_datapath.sv =====
// datapath of the text console writer: cell store, cursor, scroll base, colour
// depends on tcw_pkg; steered by tcw_ctrl through dp_cmd_type
`timescale 1ns / 1ps

module tcw_datapath #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tcw_pkg::req_type              req_payload,
   input  logic                          csr_wr_en,
   input  logic [tcw_pkg::COLOR_W-1:0]   csr_wr_data,
   input  tcw_pkg::dp_cmd_type           cmd,
   output tcw_pkg::dp_status_type        status,
   output tcw_pkg::rsp_type              rsp_payload
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int IW    = ((AW > READ_INDEX_W) ? AW : READ_INDEX_W) + 1;

   // screen store, kept as a ring of rows starting at top_base_ff
   logic [CELL_W-1:0] mem [CELLS];

   logic [COLOR_W-1:0] color_ff, color_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [AW-1:0]      row_base_ff, row_base_in;
   logic [AW-1:0]      top_base_ff, top_base_in;
   logic [AW-1:0]      sweep_ff, sweep_in;
   req_type            req_ff;
   logic [AW-1:0]      addr_ff;
   logic               in_range_ff;
   logic [CELL_W-1:0]  rdata_ff;
   rsp_type            rsp_ff;

   logic              is_read, is_newline, last_col, last_row, goes_next_row;
   logic [AW:0]       row_sum, top_sum;
   logic [AW-1:0]     next_row_base, next_top_base;
   logic [IW-1:0]     ridx_ext, rd_sum;
   logic              rd_in_range;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_offset, wr_addr;
   logic              wr_en;
   logic [CELL_W-1:0] wr_data;

   assign is_read       = (req_ff.func == FUNC_READ);
   assign is_newline    = (req_ff.char_code == NEWLINE_CODE);
   assign last_col      = (col_ff == CW'(COLUMNS - 1));
   assign last_row      = (row_ff == RW'(ROWS - 1));
   assign goes_next_row = is_newline || last_col;

   assign status.is_read     = is_read;
   assign status.need_scroll = !is_read && goes_next_row && last_row;
   assign status.clear_last  = (sweep_ff == AW'(CELLS - 1));
   assign status.blank_last  = (sweep_ff == AW'(COLUMNS - 1));

   // one row forward in the ring, wrapping at the end of the store
   always_comb begin
      row_sum = {1'b0, row_base_ff} + (AW+1)'(COLUMNS);
      if (row_sum >= (AW+1)'(CELLS)) next_row_base = AW'(row_sum - (AW+1)'(CELLS));
      else                           next_row_base = AW'(row_sum);
      top_sum = {1'b0, top_base_ff} + (AW+1)'(COLUMNS);
      if (top_sum >= (AW+1)'(CELLS)) next_top_base = AW'(top_sum - (AW+1)'(CELLS));
      else                           next_top_base = AW'(top_sum);
   end

   // logical read index to ring address
   always_comb begin
      ridx_ext    = IW'(req_ff.read_index);
      rd_in_range = (ridx_ext < IW'(CELLS));
      rd_sum      = ridx_ext + IW'(top_base_ff);
      if (rd_sum >= IW'(CELLS)) rd_addr = AW'(rd_sum - IW'(CELLS));
      else                      rd_addr = AW'(rd_sum);
   end

   always_comb begin
      wr_offset = cmd.exec_item ? AW'(col_ff) : sweep_ff;
      wr_addr   = cmd.clear_write ? sweep_ff : (row_base_ff + wr_offset);
      wr_en     = cmd.clear_write || cmd.blank_write ||
                  (cmd.exec_item && !is_read && !is_newline);
      if (cmd.clear_write)      wr_data = RESET_CELL;
      else if (cmd.blank_write) wr_data = {color_ff, SPACE_CODE};
      else                      wr_data = {color_ff, req_ff.char_code};
   end

   always_comb begin
      color_in    = csr_wr_en ? csr_wr_data : color_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      row_base_in = row_base_ff;
      top_base_in = top_base_ff;
      sweep_in    = sweep_ff;
      if (cmd.clear_write || cmd.blank_write) sweep_in = sweep_ff + AW'(1);
      else if (cmd.capture)                   sweep_in = '0;
      if (cmd.exec_item && !is_read) begin
         if (goes_next_row) begin
            col_in      = '0;
            row_base_in = next_row_base;
            // on the bottom row the cursor stays put and the ring scrolls
            if (!last_row) row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (cmd.blank_write && status.blank_last) top_base_in = next_top_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff    <= TEXT_COLOR_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         row_base_ff <= '0;
         top_base_ff <= '0;
         sweep_ff    <= '0;
      end else begin
         color_ff    <= color_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         row_base_ff <= row_base_in;
         top_base_ff <= top_base_in;
         sweep_ff    <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_payload;
      if (cmd.exec_item && is_read) begin
         addr_ff     <= rd_addr;
         in_range_ff <= rd_in_range;
      end
      if (cmd.load_rsp) begin
         rsp_ff.cell_entry <= (is_read && in_range_ff) ? rdata_ff : '0;
         rsp_ff.cursor_row <= ROW_OUT_W'(row_ff);
         rsp_ff.cursor_col <= COL_OUT_W'(col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[addr_ff];
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/text_console_writer_unit.sv =====
`timescale 1ns / 1ps
// Text console writer: a ROWS x COLUMNS store of 16-bit cells (character low,
// attribute high) with a write cursor.
// Request channel (req_valid / req_stall / req_payload): func selects put
// (print char_code at the cursor, newline code moves to the next row) or read
// (return the cell at read_index). Every request gives exactly one response on
// rsp_valid / rsp_stall / rsp_payload, carrying the cell read (zero for puts
// and for indexes past the store) and the cursor after the request.
// csr_wr_en / csr_wr_data write the attribute byte used for new characters
// and for blanked lines; write it only while the block is idle.
// Sequence: a put or newline runs an execute and a finish state before its
// response is registered, and the next request is taken only once the
// response is loaded; a read adds a read state for the registered store read.
// Leaving the bottom row scrolls: the store is a ring of rows, so only the
// new bottom line is blanked, one cell per cycle on the single write port.
// After reset all ROWS*COLUMNS cells (2000 by default) are filled with light
// grey spaces with req_stall high; the cursor goes to row 0, column 0.
// While the receiver stalls, the response holds and at most one further
// request is taken and processed up to its response.
// depends on tcw_pkg, tcw_ctrl, tcw_datapath and assert_macros.svh
`include "assert_macros.svh"

module text_console_writer_unit #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  tcw_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tcw_pkg::rsp_type            rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [tcw_pkg::COLOR_W-1:0] csr_wr_data
);
   import tcw_pkg::*;

   dp_cmd_type    cmd_s;
   dp_status_type status_s;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status_s),
      .cmd       (cmd_s)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd_s),
      .status      (status_s),
      .rsp_payload (rsp_payload)
   );

   // a pending response is never overwritten
   `TCW_ASSERT_HOLDS(a_no_rsp_overwrite, cmd_s.load_rsp, !rsp_valid || !rsp_stall)
   // no request is taken during the fill pass
   `TCW_ASSERT_HOLDS(a_clear_blocks_req, cmd_s.clear_write, req_stall)
   // an accepted request is executed in the next cycle
   `TCW_ASSERT_NEXT(a_exec_after_accept, req_valid && !req_stall, cmd_s.exec_item)
   // the blanking pass stops after its last cell
   `TCW_ASSERT_NEXT(a_blank_pass_ends, cmd_s.blank_write && status_s.blank_last,
                    !cmd_s.blank_write)

endmodule
